// File: src/lcu_pkg.sv
// Shared types and constants of the logic cell unit.
package lcu_pkg;

    localparam int NUM_CELLS        = 3;
    localparam int INPUTS_PER_CELL  = 4;
    localparam int OUTPUTS_PER_CELL = 4;
    localparam int NUM_LINES        = NUM_CELLS * INPUTS_PER_CELL;
    localparam int NUM_OUTS         = NUM_CELLS * OUTPUTS_PER_CELL;
    localparam int LINE_W           = $clog2(NUM_LINES);
    localparam int SEL_W            = 6;
    localparam int TT_W             = 16;
    localparam int WA_W             = 10;
    localparam int LINE_IDX_W       = 4;

    // word addresses (byte offset / 4)
    localparam int WA_CELL_STRIDE_LOG2 = 4;
    localparam int WA_SEL_BASE       = 'h080;
    localparam int WA_GLOBAL_CFG     = 'h0A0;
    localparam int WA_OVR_EN         = 'h0A1;
    localparam int WA_OVR_VAL        = 'h0A2;
    localparam int WA_OE_MASK        = 'h0A3;
    localparam int WA_IN_LEVELS      = 'h0A4;
    localparam int WA_OVR_ACTIVE     = 'h0A5;
    localparam int WA_OUT_LEVELS     = 'h0A6;
    localparam int WA_FORCE_SUMMARY  = 'h0A7;
    localparam int WA_FORCE_STATUS   = 'h0A8;
    localparam int WA_DEBUG_EN       = 'h0AA;

    // word offsets within a cell block
    localparam logic [3:0] CW_TT_BASE   = 4'd0;
    localparam logic [3:0] CW_FILT_BASE = 4'd4;
    localparam logic [3:0] CW_IRQ_EN    = 4'd8;
    localparam logic [3:0] CW_CHG_STAT  = 4'd9;
    localparam logic [3:0] CW_INVERT    = 4'd10;
    localparam logic [3:0] CW_FAST_FILT = 4'd11;
    localparam logic [3:0] CW_FORCE     = 4'd12;
    localparam logic [3:0] CW_SEQUENCE  = 4'd13;

    localparam int FORCE_VAL_LSB = 16;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [OUTPUTS_PER_CELL-1:0] out_en;
        logic [OUTPUTS_PER_CELL-1:0] ovr_en;
        logic [OUTPUTS_PER_CELL-1:0] ovr_val;
        logic [OUTPUTS_PER_CELL-1:0] force_en;
        logic [OUTPUTS_PER_CELL-1:0] force_val;
        logic [OUTPUTS_PER_CELL-1:0] irq_en;
        logic [INPUTS_PER_CELL-1:0]  invert;
    } t_cell_ctrl;

    typedef struct packed {
        logic [OUTPUTS_PER_CELL-1:0] levels;
        logic [OUTPUTS_PER_CELL-1:0] changed;
        logic                        pulse;
    } t_cell_stat;

endpackage

// File: src/lcu_cell.sv
// One logic cell: input selection, truth table lookup, priority and change detect.
module lcu_cell (
    input  logic [lcu_pkg::NUM_LINES-1:0]        i_levels,
    input  logic [lcu_pkg::SEL_W-1:0]            i_sel [lcu_pkg::INPUTS_PER_CELL],
    input  logic [lcu_pkg::TT_W-1:0]             i_tt  [lcu_pkg::OUTPUTS_PER_CELL],
    input  lcu_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [lcu_pkg::OUTPUTS_PER_CELL-1:0] i_prev,
    output lcu_pkg::t_cell_stat                  o_stat
);

    logic [lcu_pkg::INPUTS_PER_CELL-1:0]  idx;
    logic [lcu_pkg::OUTPUTS_PER_CELL-1:0] lvl;

    always_comb begin
        for (int k = 0; k < lcu_pkg::INPUTS_PER_CELL; k++) begin
            if (i_sel[k] < lcu_pkg::SEL_W'(lcu_pkg::NUM_LINES)) begin
                idx[k] = i_levels[i_sel[k][lcu_pkg::LINE_W-1:0]] ^ i_ctrl.invert[k];
            end else begin
                idx[k] = i_ctrl.invert[k];
            end
        end
        for (int o = 0; o < lcu_pkg::OUTPUTS_PER_CELL; o++) begin
            if (!i_ctrl.out_en[o]) begin
                lvl[o] = 1'b0;
            end else if (i_ctrl.ovr_en[o]) begin
                lvl[o] = i_ctrl.ovr_val[o];
            end else if (i_ctrl.force_en[o]) begin
                lvl[o] = i_ctrl.force_val[o];
            end else begin
                lvl[o] = i_tt[o][idx];
            end
        end
        o_stat.levels  = lvl;
        o_stat.changed = lvl ^ i_prev;
        o_stat.pulse   = |((lvl ^ i_prev) & i_ctrl.irq_en);
    end

endmodule

// File: src/lut_logic_cell_unit.sv
// Top level of the logic cell unit: register file, line filters, cells, result register.
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | opcode, word_address, write_data,
//          |           |                            | line_index, line_level
//  result  | out       | o_out_valid / i_out_ready  | read_data, output_levels,
//          |           |                            | cell_irq_pulse
//
// One item per cycle sustained while results are taken; an item waits in the input
// register and its result is captured in the result register as the item advances. All
// state updates and the cell evaluation happen in the single step from input register to
// result register. Synchronous active-low reset clears all but the payload registers.
// A held result stalls that step; the input register then fills and ready drops.
module lut_logic_cell_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_word_address,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_line_index,
    input  logic        i_line_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic [11:0] o_output_levels,
    output logic [2:0]  o_cell_irq_pulse
);

    localparam int NC  = lcu_pkg::NUM_CELLS;
    localparam int IPC = lcu_pkg::INPUTS_PER_CELL;
    localparam int OPC = lcu_pkg::OUTPUTS_PER_CELL;
    localparam int NL  = lcu_pkg::NUM_LINES;
    localparam int NO  = lcu_pkg::NUM_OUTS;
    localparam int WAW = lcu_pkg::WA_W;

    // input register
    logic                  r_in_valid;
    lcu_pkg::t_opcode      r_op;
    logic [WAW-1:0]        r_wa;
    logic [31:0]           r_wd;
    logic [3:0]            r_li;
    logic                  r_ll;

    // result register
    logic                  r_out_valid;
    logic [31:0]           r_rd;
    logic [NO-1:0]         r_lvls;
    logic [NC-1:0]         r_pulse;

    // register file
    logic [lcu_pkg::TT_W-1:0] r_tt    [NO], n_tt    [NO];
    logic [31:0]              r_sel   [NL], n_sel   [NL];
    logic [31:0]              r_filt  [NL], n_filt  [NL];
    logic [31:0]              r_irq_en[NC], n_irq_en[NC];
    logic [OPC-1:0]           r_chg   [NC], n_chg   [NC];
    logic [31:0]              r_inv   [NC], n_inv   [NC];
    logic [31:0]              r_fast  [NC], n_fast  [NC];
    logic [31:0]              r_force [NC], n_force [NC];
    logic [31:0]              r_seq   [NC], n_seq   [NC];
    logic [31:0]              r_global, n_global;
    logic [31:0]              r_ovr_en, n_ovr_en;
    logic [31:0]              r_ovr_val, n_ovr_val;
    logic [31:0]              r_oe_mask, n_oe_mask;
    logic [31:0]              r_force_stat, n_force_stat;
    logic [31:0]              r_debug, n_debug;
    logic [NL-1:0]            r_in_lvl, n_in_lvl;
    logic [NL-1:0]            r_pend_v, n_pend_v;
    logic [NL-1:0]            r_pend_l, n_pend_l;
    logic [NO-1:0]            r_out_lvl, n_out_lvl;

    logic                     advance;
    logic                     cell_blk;
    logic [3:0]               cw;
    logic [31:0]              rd;
    logic [NC-1:0]            pulse;

    lcu_pkg::t_cell_ctrl      cell_ctrl [NC];
    lcu_pkg::t_cell_stat      cell_stat [NC];

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign cw         = r_wa[3:0];
    assign cell_blk   = r_wa < WAW'(NC << lcu_pkg::WA_CELL_STRIDE_LOG2);

    // register read, from state before this item
    always_comb begin
        rd = '0;
        if (r_op == lcu_pkg::OP_READ) begin
            for (int c = 0; c < NC; c++) begin
                if (cell_blk && r_wa[WAW-1:4] == (WAW-4)'(c)) begin
                    for (int o = 0; o < OPC; o++) begin
                        if (cw == lcu_pkg::CW_TT_BASE + 4'(o)) begin
                            rd = 32'(r_tt[c*OPC+o]);
                        end
                    end
                    for (int k = 0; k < IPC; k++) begin
                        if (cw == lcu_pkg::CW_FILT_BASE + 4'(k)) begin
                            rd = r_filt[c*IPC+k];
                        end
                    end
                    case (cw)
                        lcu_pkg::CW_IRQ_EN:    rd = r_irq_en[c];
                        lcu_pkg::CW_CHG_STAT:  rd = 32'(r_chg[c]);
                        lcu_pkg::CW_INVERT:    rd = r_inv[c];
                        lcu_pkg::CW_FAST_FILT: rd = r_fast[c];
                        lcu_pkg::CW_FORCE:     rd = r_force[c];
                        lcu_pkg::CW_SEQUENCE:  rd = r_seq[c];
                        default:               ;
                    endcase
                end
            end
            for (int l = 0; l < NL; l++) begin
                if (r_wa == WAW'(lcu_pkg::WA_SEL_BASE + l)) begin
                    rd = r_sel[l];
                end
            end
            if (r_wa == WAW'(lcu_pkg::WA_GLOBAL_CFG))    rd = r_global;
            if (r_wa == WAW'(lcu_pkg::WA_OVR_EN))        rd = r_ovr_en;
            if (r_wa == WAW'(lcu_pkg::WA_OVR_VAL))       rd = r_ovr_val;
            if (r_wa == WAW'(lcu_pkg::WA_OE_MASK))       rd = r_oe_mask;
            if (r_wa == WAW'(lcu_pkg::WA_IN_LEVELS))     rd = 32'(r_in_lvl);
            if (r_wa == WAW'(lcu_pkg::WA_OVR_ACTIVE))    rd = r_ovr_en & r_ovr_val;
            if (r_wa == WAW'(lcu_pkg::WA_OUT_LEVELS))    rd = 32'(r_out_lvl);
            if (r_wa == WAW'(lcu_pkg::WA_FORCE_SUMMARY)) begin
                for (int c = 0; c < NC; c++) begin
                    rd = rd | (r_force[c] << (c * OPC));
                end
            end
            if (r_wa == WAW'(lcu_pkg::WA_FORCE_STATUS))  rd = r_force_stat;
            if (r_wa == WAW'(lcu_pkg::WA_DEBUG_EN))      rd = r_debug;
        end
    end

    // register writes and line events
    always_comb begin
        n_tt         = r_tt;
        n_sel        = r_sel;
        n_filt       = r_filt;
        n_irq_en     = r_irq_en;
        n_chg        = r_chg;
        n_inv        = r_inv;
        n_fast       = r_fast;
        n_force      = r_force;
        n_seq        = r_seq;
        n_global     = r_global;
        n_ovr_en     = r_ovr_en;
        n_ovr_val    = r_ovr_val;
        n_oe_mask    = r_oe_mask;
        n_force_stat = r_force_stat;
        n_debug      = r_debug;
        n_in_lvl     = r_in_lvl;
        n_pend_v     = r_pend_v;
        n_pend_l     = r_pend_l;
        case (r_op)
            lcu_pkg::OP_WRITE: begin
                for (int c = 0; c < NC; c++) begin
                    if (cell_blk && r_wa[WAW-1:4] == (WAW-4)'(c)) begin
                        for (int o = 0; o < OPC; o++) begin
                            if (cw == lcu_pkg::CW_TT_BASE + 4'(o)) begin
                                n_tt[c*OPC+o] = r_wd[lcu_pkg::TT_W-1:0];
                            end
                        end
                        for (int k = 0; k < IPC; k++) begin
                            if (cw == lcu_pkg::CW_FILT_BASE + 4'(k)) begin
                                n_filt[c*IPC+k] = r_wd;
                            end
                        end
                        case (cw)
                            lcu_pkg::CW_IRQ_EN:    n_irq_en[c] = r_wd;
                            lcu_pkg::CW_CHG_STAT:  n_chg[c]    = r_chg[c] & ~r_wd[OPC-1:0];
                            lcu_pkg::CW_INVERT:    n_inv[c]    = r_wd;
                            lcu_pkg::CW_FAST_FILT: n_fast[c]   = r_wd;
                            lcu_pkg::CW_FORCE:     n_force[c]  = r_wd;
                            lcu_pkg::CW_SEQUENCE:  n_seq[c]    = r_wd;
                            default:               ;
                        endcase
                    end
                end
                for (int l = 0; l < NL; l++) begin
                    if (r_wa == WAW'(lcu_pkg::WA_SEL_BASE + l)) begin
                        n_sel[l] = r_wd;
                    end
                end
                if (r_wa == WAW'(lcu_pkg::WA_GLOBAL_CFG))   n_global     = r_wd;
                if (r_wa == WAW'(lcu_pkg::WA_OVR_EN))       n_ovr_en     = r_wd;
                if (r_wa == WAW'(lcu_pkg::WA_OVR_VAL))      n_ovr_val    = r_wd;
                if (r_wa == WAW'(lcu_pkg::WA_OE_MASK))      n_oe_mask    = r_wd;
                if (r_wa == WAW'(lcu_pkg::WA_FORCE_STATUS)) n_force_stat = r_wd;
                if (r_wa == WAW'(lcu_pkg::WA_DEBUG_EN))     n_debug      = r_wd;
            end
            lcu_pkg::OP_LINE: begin
                for (int l = 0; l < NL; l++) begin
                    if (r_li == lcu_pkg::LINE_IDX_W'(l)) begin
                        if (r_filt[l][0]) begin
                            // confirm filter: level taken on the second matching event
                            if (r_pend_v[l] && r_pend_l[l] == r_ll) begin
                                n_in_lvl[l] = r_ll;
                                n_pend_v[l] = 1'b0;
                            end else begin
                                n_pend_v[l] = 1'b1;
                                n_pend_l[l] = r_ll;
                            end
                        end else begin
                            n_in_lvl[l] = r_ll;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // cells evaluate on the updated state
    for (genvar c = 0; c < NC; c++) begin : g_cell
        logic [lcu_pkg::SEL_W-1:0] sel_lo [IPC];
        logic [lcu_pkg::TT_W-1:0]  tt     [OPC];

        always_comb begin
            for (int k = 0; k < IPC; k++) begin
                sel_lo[k] = n_sel[c*IPC+k][lcu_pkg::SEL_W-1:0];
            end
            for (int o = 0; o < OPC; o++) begin
                tt[o] = n_tt[c*OPC+o];
            end
            cell_ctrl[c].out_en    = n_oe_mask[c*OPC +: OPC];
            cell_ctrl[c].ovr_en    = n_ovr_en[c*OPC +: OPC];
            cell_ctrl[c].ovr_val   = n_ovr_val[c*OPC +: OPC];
            cell_ctrl[c].force_en  = n_force[c][OPC-1:0];
            cell_ctrl[c].force_val = n_force[c][lcu_pkg::FORCE_VAL_LSB +: OPC];
            cell_ctrl[c].irq_en    = n_irq_en[c][OPC-1:0];
            cell_ctrl[c].invert    = n_inv[c][IPC-1:0];
        end

        lcu_cell u_cell (
            .i_levels (n_in_lvl),
            .i_sel    (sel_lo),
            .i_tt     (tt),
            .i_ctrl   (cell_ctrl[c]),
            .i_prev   (r_out_lvl[c*OPC +: OPC]),
            .o_stat   (cell_stat[c])
        );

        assign n_out_lvl[c*OPC +: OPC] = cell_stat[c].levels;
        assign pulse[c]                = cell_stat[c].pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_global     <= '0;
            r_ovr_en     <= '0;
            r_ovr_val    <= '0;
            r_oe_mask    <= '0;
            r_force_stat <= '0;
            r_debug      <= '0;
            r_in_lvl     <= '0;
            r_pend_v     <= '0;
            r_pend_l     <= '0;
            r_out_lvl    <= '0;
            for (int i = 0; i < NO; i++) begin
                r_tt[i] <= '0;
            end
            for (int i = 0; i < NL; i++) begin
                r_sel[i]  <= '0;
                r_filt[i] <= '0;
            end
            for (int i = 0; i < NC; i++) begin
                r_irq_en[i] <= '0;
                r_chg[i]    <= '0;
                r_inv[i]    <= '0;
                r_fast[i]   <= '0;
                r_force[i]  <= '0;
                r_seq[i]    <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_tt         <= n_tt;
                r_sel        <= n_sel;
                r_filt       <= n_filt;
                r_irq_en     <= n_irq_en;
                r_inv        <= n_inv;
                r_fast       <= n_fast;
                r_force      <= n_force;
                r_seq        <= n_seq;
                r_global     <= n_global;
                r_ovr_en     <= n_ovr_en;
                r_ovr_val    <= n_ovr_val;
                r_oe_mask    <= n_oe_mask;
                r_force_stat <= n_force_stat;
                r_debug      <= n_debug;
                r_in_lvl     <= n_in_lvl;
                r_pend_v     <= n_pend_v;
                r_pend_l     <= n_pend_l;
                r_out_lvl    <= n_out_lvl;
                for (int c = 0; c < NC; c++) begin
                    r_chg[c] <= n_chg[c] | cell_stat[c].changed;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op <= lcu_pkg::t_opcode'(i_opcode);
            r_wa <= i_word_address;
            r_wd <= i_write_data;
            r_li <= i_line_index;
            r_ll <= i_line_level;
        end
        if (advance) begin
            r_rd    <= rd;
            r_lvls  <= n_out_lvl;
            r_pulse <= pulse;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_rd;
    assign o_output_levels  = r_lvls;
    assign o_cell_irq_pulse = r_pulse;

endmodule

// File: sim/tb_lut_logic_cell_unit.sv
// Self-checking testbench of lut_logic_cell_unit: queued stimulus, clocked driver and monitor.
module tb_lut_logic_cell_unit;

    localparam int RND_PER_PHASE = 367;
    localparam int WDOG_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        lcu_pkg::t_opcode op;
        logic [9:0]       wa;
        logic [31:0]      wd;
        logic [3:0]       li;
        logic             ll;
        logic [1:0]       phase;
    } t_lcu_item;

    typedef struct packed {
        logic [31:0] rd;
        logic [11:0] lvls;
        logic [2:0]  irq;
    } t_lcu_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_opcode;
    logic [9:0]  i_word_address;
    logic [31:0] i_write_data;
    logic [3:0]  i_line_index;
    logic        i_line_level;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_read_data;
    logic [11:0] o_output_levels;
    logic [2:0]  o_cell_irq_pulse;

    lut_logic_cell_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_word_address  (i_word_address),
        .i_write_data    (i_write_data),
        .i_line_index    (i_line_index),
        .i_line_level    (i_line_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_output_levels (o_output_levels),
        .o_cell_irq_pulse(o_cell_irq_pulse)
    );

    // shadow copy of the unit's state
    logic [lcu_pkg::NUM_OUTS-1:0][15:0]                            truth_tbl;
    logic [lcu_pkg::NUM_LINES-1:0][31:0]                           line_sel;
    logic [lcu_pkg::NUM_LINES-1:0][31:0]                           line_filt;
    logic [lcu_pkg::NUM_CELLS-1:0][31:0]                           cell_irq_en;
    logic [lcu_pkg::NUM_CELLS-1:0][lcu_pkg::OUTPUTS_PER_CELL-1:0]  cell_chg;
    logic [lcu_pkg::NUM_CELLS-1:0][31:0]                           cell_inv;
    logic [lcu_pkg::NUM_CELLS-1:0][31:0]                           cell_fast;
    logic [lcu_pkg::NUM_CELLS-1:0][31:0]                           cell_frc;
    logic [lcu_pkg::NUM_CELLS-1:0][31:0]                           cell_seq;
    logic [31:0] glb_cfg, ovr_en, ovr_val, oe_mask, frc_stat, dbg_en;
    logic [lcu_pkg::NUM_LINES-1:0] in_lvl, pend_vld, pend_lvl;
    logic [lcu_pkg::NUM_OUTS-1:0]  out_lvl;

    t_lcu_item stim_q[$];
    t_lcu_res  exp_res_q[$];

    int   total_items;
    int   in_acc_cnt;
    int   err_cnt;
    int   idle_cyc;
    int   hold_at;
    int   hold_cnt;
    logic hold_done;
    logic in_took;
    logic [1:0] cur_phase;
    logic [1:0] rx_phase;

    function automatic int tx_idle_pct(logic [1:0] ph);
        case (ph)
            2'd0:    return 34;
            2'd1:    return 69;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(logic [1:0] ph);
        case (ph)
            2'd0:    return 69;
            2'd1:    return 34;
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] reg_value(logic [9:0] wa);
        logic [63:0] acc;
        int c;
        logic [3:0] w;
        c = wa >> lcu_pkg::WA_CELL_STRIDE_LOG2;
        w = wa[3:0];
        if (wa < (lcu_pkg::NUM_CELLS << lcu_pkg::WA_CELL_STRIDE_LOG2)) begin
            if (w < lcu_pkg::CW_FILT_BASE)
                return {16'h0, truth_tbl[c*lcu_pkg::OUTPUTS_PER_CELL + w]};
            if (w < lcu_pkg::CW_IRQ_EN)
                return line_filt[c*lcu_pkg::INPUTS_PER_CELL + (w - lcu_pkg::CW_FILT_BASE)];
            case (w)
                lcu_pkg::CW_IRQ_EN:    return cell_irq_en[c];
                lcu_pkg::CW_CHG_STAT:  return 32'(cell_chg[c]);
                lcu_pkg::CW_INVERT:    return cell_inv[c];
                lcu_pkg::CW_FAST_FILT: return cell_fast[c];
                lcu_pkg::CW_FORCE:     return cell_frc[c];
                lcu_pkg::CW_SEQUENCE:  return cell_seq[c];
                default:               return 32'h0;
            endcase
        end
        if (wa >= lcu_pkg::WA_SEL_BASE && wa < lcu_pkg::WA_SEL_BASE + lcu_pkg::NUM_LINES)
            return line_sel[wa - lcu_pkg::WA_SEL_BASE];
        case (int'(wa))
            lcu_pkg::WA_GLOBAL_CFG:    return glb_cfg;
            lcu_pkg::WA_OVR_EN:        return ovr_en;
            lcu_pkg::WA_OVR_VAL:       return ovr_val;
            lcu_pkg::WA_OE_MASK:       return oe_mask;
            lcu_pkg::WA_IN_LEVELS:     return 32'(in_lvl);
            lcu_pkg::WA_OVR_ACTIVE:    return ovr_en & ovr_val;
            lcu_pkg::WA_OUT_LEVELS:    return 32'(out_lvl);
            lcu_pkg::WA_FORCE_SUMMARY: begin
                acc = '0;
                for (int i = 0; i < lcu_pkg::NUM_CELLS; i++)
                    acc = acc | (64'(cell_frc[i]) << (i * lcu_pkg::OUTPUTS_PER_CELL));
                return acc[31:0];
            end
            lcu_pkg::WA_FORCE_STATUS:  return frc_stat;
            lcu_pkg::WA_DEBUG_EN:      return dbg_en;
            default:                   return 32'h0;
        endcase
    endfunction

    task automatic reg_store(logic [9:0] wa, logic [31:0] v);
        int c;
        logic [3:0] w;
        c = wa >> lcu_pkg::WA_CELL_STRIDE_LOG2;
        w = wa[3:0];
        if (wa < (lcu_pkg::NUM_CELLS << lcu_pkg::WA_CELL_STRIDE_LOG2)) begin
            if (w < lcu_pkg::CW_FILT_BASE)
                truth_tbl[c*lcu_pkg::OUTPUTS_PER_CELL + w] = v[15:0];
            else if (w < lcu_pkg::CW_IRQ_EN)
                line_filt[c*lcu_pkg::INPUTS_PER_CELL + (w - lcu_pkg::CW_FILT_BASE)] = v;
            else begin
                case (w)
                    lcu_pkg::CW_IRQ_EN:    cell_irq_en[c] = v;
                    lcu_pkg::CW_CHG_STAT:
                        cell_chg[c] = cell_chg[c] & ~v[lcu_pkg::OUTPUTS_PER_CELL-1:0];
                    lcu_pkg::CW_INVERT:    cell_inv[c] = v;
                    lcu_pkg::CW_FAST_FILT: cell_fast[c] = v;
                    lcu_pkg::CW_FORCE:     cell_frc[c] = v;
                    lcu_pkg::CW_SEQUENCE:  cell_seq[c] = v;
                    default:               ;
                endcase
            end
        end else if (wa >= lcu_pkg::WA_SEL_BASE &&
                     wa < lcu_pkg::WA_SEL_BASE + lcu_pkg::NUM_LINES) begin
            line_sel[wa - lcu_pkg::WA_SEL_BASE] = v;
        end else begin
            case (int'(wa))
                lcu_pkg::WA_GLOBAL_CFG:   glb_cfg = v;
                lcu_pkg::WA_OVR_EN:       ovr_en = v;
                lcu_pkg::WA_OVR_VAL:      ovr_val = v;
                lcu_pkg::WA_OE_MASK:      oe_mask = v;
                lcu_pkg::WA_FORCE_STATUS: frc_stat = v;
                lcu_pkg::WA_DEBUG_EN:     dbg_en = v;
                default:                  ;
            endcase
        end
    endtask

    // applies one item to the shadow state and works out its result
    task automatic lcu_step(t_lcu_item it, output t_lcu_res r);
        logic [3:0] idx;
        logic [5:0] s;
        logic       b;
        int         n;
        r = '0;
        case (it.op)
            lcu_pkg::OP_LINE: begin
                if (it.li < lcu_pkg::NUM_LINES) begin
                    if (line_filt[it.li][0]) begin
                        if (pend_vld[it.li] && pend_lvl[it.li] == it.ll) begin
                            in_lvl[it.li] = it.ll;
                            pend_vld[it.li] = 1'b0;
                        end else begin
                            pend_vld[it.li] = 1'b1;
                            pend_lvl[it.li] = it.ll;
                        end
                    end else begin
                        in_lvl[it.li] = it.ll;
                    end
                end
            end
            lcu_pkg::OP_READ:  r.rd = reg_value(it.wa);
            lcu_pkg::OP_WRITE: reg_store(it.wa, it.wd);
            default:           ;
        endcase
        for (int c = 0; c < lcu_pkg::NUM_CELLS; c++) begin
            idx = '0;
            for (int k = 0; k < lcu_pkg::INPUTS_PER_CELL; k++) begin
                s = line_sel[c*lcu_pkg::INPUTS_PER_CELL + k][lcu_pkg::SEL_W-1:0];
                b = (s < lcu_pkg::NUM_LINES) ? in_lvl[s] : 1'b0;
                idx[k] = b ^ cell_inv[c][k];
            end
            for (int o = 0; o < lcu_pkg::OUTPUTS_PER_CELL; o++) begin
                n = c*lcu_pkg::OUTPUTS_PER_CELL + o;
                if (!oe_mask[n]) b = 1'b0;
                else if (ovr_en[n]) b = ovr_val[n];
                else if (cell_frc[c][o]) b = cell_frc[c][lcu_pkg::FORCE_VAL_LSB + o];
                else b = truth_tbl[n][idx];
                if (b != out_lvl[n]) begin
                    out_lvl[n] = b;
                    cell_chg[c][o] = 1'b1;
                    if (cell_irq_en[c][o]) r.irq[c] = 1'b1;
                end
            end
        end
        r.lvls = out_lvl;
    endtask

    task automatic push_item(lcu_pkg::t_opcode op, logic [9:0] wa, logic [31:0] wd,
                             logic [3:0] li, logic ll, logic [1:0] ph);
        t_lcu_item it;
        it.op = op;
        it.wa = wa;
        it.wd = wd;
        it.li = li;
        it.ll = ll;
        it.phase = ph;
        stim_q.push_back(it);
    endtask

    function automatic logic [9:0] rand_addr();
        case ($urandom_range(0, 3))
            0, 1:    return 10'((($urandom_range(0, lcu_pkg::NUM_CELLS-1))
                                 << lcu_pkg::WA_CELL_STRIDE_LOG2)
                                | $urandom_range(0, 13));
            2:       return 10'(lcu_pkg::WA_SEL_BASE
                                + $urandom_range(0, lcu_pkg::NUM_LINES-1));
            default: return 10'($urandom_range(lcu_pkg::WA_GLOBAL_CFG, lcu_pkg::WA_DEBUG_EN));
        endcase
    endfunction

    function automatic logic [31:0] rand_data(logic [9:0] wa);
        logic [31:0] d;
        d = $urandom;
        if (wa >= lcu_pkg::WA_SEL_BASE && wa < lcu_pkg::WA_SEL_BASE + lcu_pkg::NUM_LINES
            && $urandom_range(0, 3) != 0)
            d = $urandom_range(0, lcu_pkg::NUM_LINES-1);
        else if (wa == lcu_pkg::WA_OE_MASK && $urandom_range(0, 4) != 0)
            d = d | 32'hFFF;
        else if (wa == lcu_pkg::WA_OVR_EN)
            d = d & $urandom & $urandom;
        return d;
    endfunction

    task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt < 100)
                $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    always #2 i_clk = ~i_clk;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (stim_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct(stim_q[0].phase)) begin
                i_opcode       <= stim_q[0].op;
                i_word_address <= stim_q[0].wa;
                i_write_data   <= stim_q[0].wd;
                i_line_index   <= stim_q[0].li;
                i_line_level   <= stim_q[0].ll;
                cur_phase      <= stim_q[0].phase;
                i_in_valid     <= 1'b1;
                void'(stim_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender keeps offering items
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && in_acc_cnt >= hold_at) begin
            hold_cnt    <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct(rx_phase));
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin : mon
        t_lcu_item it;
        t_lcu_res  want;
        logic      out_fire;
        logic      in_fire;
        out_fire = o_out_valid && i_out_ready;
        in_fire  = i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (out_fire) begin
                if (exp_res_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt < 100)
                        $display("%0t unexpected result: expected none actual %h %h %h",
                                 $time, o_read_data, o_output_levels, o_cell_irq_pulse);
                end else begin
                    want = exp_res_q.pop_front();
                    cmp_field("read_data", want.rd, o_read_data);
                    cmp_field("output_levels", 32'(want.lvls), 32'(o_output_levels));
                    cmp_field("cell_irq_pulse", 32'(want.irq), 32'(o_cell_irq_pulse));
                end
            end
            if (in_fire) begin
                it.op    = lcu_pkg::t_opcode'(i_opcode);
                it.wa    = i_word_address;
                it.wd    = i_write_data;
                it.li    = i_line_index;
                it.ll    = i_line_level;
                it.phase = cur_phase;
                lcu_step(it, want);
                exp_res_q.push_back(want);
                in_acc_cnt <= in_acc_cnt + 1;
                rx_phase   <= cur_phase;
            end
            in_took <= in_fire;
            if (out_fire || in_fire) begin
                idle_cyc <= 0;
            end else if (idle_cyc >= WDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
        end
    end

    initial begin
        int r;
        logic [9:0] wa;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_opcode = lcu_pkg::OP_NOP;
        i_word_address = '0;
        i_write_data = '0;
        i_line_index = '0;
        i_line_level = 1'b0;
        in_took = 1'b0;
        cur_phase = 2'd0;
        rx_phase = 2'd0;
        in_acc_cnt = 0;
        err_cnt = 0;
        idle_cyc = 0;
        hold_cnt = 0;
        hold_done = 1'b0;
        hold_at = 32'h7FFFFFFF;
        truth_tbl = '0; line_sel = '0; line_filt = '0;
        cell_irq_en = '0; cell_chg = '0; cell_inv = '0;
        cell_fast = '0; cell_frc = '0; cell_seq = '0;
        glb_cfg = '0; ovr_en = '0; ovr_val = '0; oe_mask = '0; frc_stat = '0; dbg_en = '0;
        in_lvl = '0; pend_vld = '0; pend_lvl = '0; out_lvl = '0;

        // directed part
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::WA_OUT_LEVELS), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_OE_MASK), 32'hFFFF_FFFF, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::CW_TT_BASE), 32'hFFFF_FFFF, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::CW_IRQ_EN), 32'hFFFF_FFFF, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::CW_TT_BASE + 1), 32'h0000_0001, '0, 1'b0,
                  2'd0);
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::CW_CHG_STAT), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::CW_CHG_STAT), 32'h0000_0001, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::CW_CHG_STAT), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_SEL_BASE), 32'd5, '0, 1'b0, 2'd0);
        // selector past the last line
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_SEL_BASE + 1), 32'h0000_003F, '0, 1'b0,
                  2'd0);
        push_item(lcu_pkg::OP_LINE,  '0, '0, 4'd5, 1'b1, 2'd0);
        push_item(lcu_pkg::OP_LINE,  '0, '0, 4'd15, 1'b1, 2'd0);
        // confirm filter on line 0
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::CW_FILT_BASE), 32'h0000_0001, '0, 1'b0,
                  2'd0);
        push_item(lcu_pkg::OP_LINE,  '0, '0, 4'd0, 1'b1, 2'd0);
        push_item(lcu_pkg::OP_LINE,  '0, '0, 4'd0, 1'b1, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::WA_IN_LEVELS), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE,
                  10'((1 << lcu_pkg::WA_CELL_STRIDE_LOG2) + lcu_pkg::CW_FORCE),
                  32'h000F_000F, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_OVR_EN), 32'h0000_0FFF, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_OVR_VAL), 32'h0000_0AAA, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::WA_OVR_ACTIVE), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'(lcu_pkg::WA_FORCE_SUMMARY), '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_IN_LEVELS), 32'hFFFF_FFFF, '0, 1'b0,
                  2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'h3FF, 32'hFFFF_FFFF, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'h3FF, 32'hFFFF_FFFF, 4'hF, 1'b1, 2'd0);
        push_item(lcu_pkg::OP_READ,  10'd14, '0, '0, 1'b0, 2'd0);
        push_item(lcu_pkg::OP_NOP,   10'h2AA, 32'h5555_AAAA, 4'd3, 1'b1, 2'd0);
        push_item(lcu_pkg::OP_WRITE, 10'(lcu_pkg::WA_OVR_EN), 32'h0, '0, 1'b0, 2'd0);

        // random part, one block per idling phase
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 2) hold_at = stim_q.size() + 100;
            for (int i = 0; i < RND_PER_PHASE; i++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    push_item(lcu_pkg::OP_LINE, 10'($urandom), $urandom,
                              ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                          : 4'($urandom_range(0, 11)),
                              1'($urandom), 2'(ph));
                end else if (r < 70) begin
                    wa = rand_addr();
                    push_item(lcu_pkg::OP_WRITE, wa, rand_data(wa), 4'($urandom),
                              1'($urandom), 2'(ph));
                end else if (r < 92) begin
                    push_item(lcu_pkg::OP_READ, rand_addr(), $urandom, 4'($urandom),
                              1'($urandom), 2'(ph));
                end else if (r < 97) begin
                    push_item(r[0] ? lcu_pkg::OP_READ : lcu_pkg::OP_WRITE, 10'($urandom),
                              $urandom, 4'($urandom), 1'($urandom), 2'(ph));
                end else begin
                    push_item(lcu_pkg::OP_NOP, 10'($urandom), $urandom, 4'($urandom),
                              1'($urandom), 2'(ph));
                end
            end
        end
        total_items = stim_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(in_acc_cnt == total_items && exp_res_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
